/* design/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // default sample format, signed Q1.14
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // number of divided components per matrix
  localparam int LANES = 3;

  // which component comes out of the square root
  typedef enum logic [1:0] {
    PIV_A = 2'd0,
    PIV_B = 2'd1,
    PIV_C = 2'd2,
    PIV_D = 2'd3
  } pivot_t;

endpackage

`default_nettype wire

/* design/rmq_sqrt.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per register stage, with a
// sideband word that travels alongside the operand.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt #(
  parameter int XW  = 32,
  parameter int SBW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [XW-1:0]   in_x,
  input  wire logic [SBW-1:0]  in_sb,
  output logic                 out_valid,
  output logic [XW/2-1:0]      out_root,
  output logic [SBW-1:0]       out_sb
);

  localparam int RW = XW / 2;

  logic [RW+1:0]  rem_r  [RW+1];
  logic [RW-1:0]  root_r [RW+1];
  logic [XW-1:0]  xs_r   [RW+1];
  logic [SBW-1:0] sb_r   [RW+1];
  logic           vld_r  [RW+1];

  // operand capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      xs_r[0]   <= in_x;
      sb_r[0]   <= in_sb;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+3:0] trem;
    logic [RW+3:0] trial;
    logic          ge;

    always_comb begin
      trem  = {rem_r[k], xs_r[k][XW-1:XW-2]};
      trial = (RW+4)'({root_r[k], 2'b01});
      ge    = trem >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? (RW+2)'(trem - trial) : (RW+2)'(trem);
        root_r[k+1] <= (RW)'({root_r[k], ge});
        xs_r[k+1]   <= xs_r[k] << 2;
        sb_r[k+1]   <= sb_r[k];
      end
    end
  end

  assign out_valid = vld_r[RW];
  assign out_root  = root_r[RW];
  assign out_sb    = sb_r[RW];

endmodule

`default_nettype wire

/* design/rmq_div.sv */
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, three lanes sharing one divisor: each lane
// returns num / (4 * p) rounded to nearest, ties away from zero, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div #(
  parameter int DW  = rmq_pkg::DATA_WIDTH,
  parameter int FB  = rmq_pkg::FRAC_BITS,
  parameter int PW  = 16,
  parameter int SBW = 2
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [PW-1:0]           in_p,
  input  wire logic signed [DW:0]      in_num [rmq_pkg::LANES],
  input  wire logic [SBW-1:0]          in_sb,
  output logic                         out_valid,
  output logic [PW-1:0]                out_p,
  output logic signed [DW-1:0]         out_q [rmq_pkg::LANES],
  output logic [SBW-1:0]               out_sb
);

  localparam int NW = DW + FB + 2;
  localparam int L  = rmq_pkg::LANES;
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  logic [PW+2:0]  rem_r [NW+1][L];
  logic [NW-1:0]  dq_r  [NW+1][L];
  logic           neg_r [NW+1][L];
  logic [PW-1:0]  p_r   [NW+1];
  logic [SBW-1:0] sb_r  [NW+1];
  logic           vld_r [NW+1];

  // operand capture: magnitude scaled up, half divisor added for rounding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  for (genvar l = 0; l < L; l++) begin : g_load
    logic [DW:0] mag;
    always_comb begin
      mag = in_num[l][DW] ? (DW+1)'(0) - in_num[l] : in_num[l];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0][l] <= '0;
        dq_r[0][l]  <= (NW'(mag) << FB) + (NW'(in_p) << 1);
        neg_r[0][l] <= in_num[l][DW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= in_p;
      sb_r[0] <= in_sb;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [PW+2:0] den;
    assign den = {1'b0, p_r[k], 2'b00};

    for (genvar l = 0; l < L; l++) begin : g_lane
      logic [PW+2:0] trem;
      logic          ge;
      always_comb begin
        trem = {rem_r[k][l][PW+1:0], dq_r[k][l][NW-1]};
        ge   = trem >= den;
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1][l] <= ge ? trem - den : trem;
          dq_r[k+1][l]  <= {dq_r[k][l][NW-2:0], ge};
          neg_r[k+1][l] <= neg_r[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[k+1]  <= p_r[k];
        sb_r[k+1] <= sb_r[k];
      end
    end
  end

  // sign and saturation
  for (genvar l = 0; l < L; l++) begin : g_sat
    logic [NW-1:0] q;
    logic          big;
    always_comb begin
      q   = dq_r[NW][l];
      big = (q >> (DW-1)) != '0;
      if (neg_r[NW][l]) begin
        out_q[l] = big ? SMIN : DW'(0) - DW'(q);
      end else begin
        out_q[l] = big ? SMAX : DW'(q);
      end
    end
  end

  assign out_valid = vld_r[NW];
  assign out_p     = p_r[NW];
  assign out_sb    = sb_r[NW];

endmodule

`default_nettype wire

/* design/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a 3x3 rotation matrix to quaternion components.
// ----------------------------------------------------------------------------
// Fully pipelined: a new matrix is taken every cycle while the output is
// not stalled. The pipeline is 1 (input register) + RW + 1 (bit-serial
// square root, RW = half the root operand width) + DATA_WIDTH + FRAC_BITS
// + 3 (bit-serial divider) + 1 (output register) stages deep, 51 at the
// default Q1.14 format. Throughput is one matrix per cycle; the whole
// pipeline halts while a result waits at the output. A zero pivot returns
// all components zero with the degenerate flag set in out_tuser.
`default_nettype none

module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // r11 r12 r13 r21 r22 r23 r31 r32 r33, lowest bits first
  input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // comp_a comp_b comp_c comp_d, lowest bits first
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      out_tdata,
  // degenerate
  output logic                                   out_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready
);

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int ODW = ((4*DW+7)/8)*8;
  localparam int AW  = ((DW > FB+1) ? DW : FB+1) + 3;
  localparam int SW  = AW - 1 + FB - 2;
  localparam int SQW = SW + (SW % 2);
  localparam int RW  = SQW / 2;
  localparam int NMW = DW + 1;
  localparam int L   = rmq_pkg::LANES;
  localparam int SBW = L*NMW + 2;
  localparam logic signed [AW-1:0] ONE  = AW'(1) << FB;
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};

  logic en;
  logic out_tvalid_r;

  // pipeline advances unless a result is held at the output
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // input unpack
  logic signed [DW-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  assign m11 = in_tdata[0*DW +: DW];
  assign m12 = in_tdata[1*DW +: DW];
  assign m13 = in_tdata[2*DW +: DW];
  assign m21 = in_tdata[3*DW +: DW];
  assign m22 = in_tdata[4*DW +: DW];
  assign m23 = in_tdata[5*DW +: DW];
  assign m31 = in_tdata[6*DW +: DW];
  assign m32 = in_tdata[7*DW +: DW];
  assign m33 = in_tdata[8*DW +: DW];

  // pivot selection, root argument and off-diagonal numerators
  rmq_pkg::pivot_t      sel_nxt;
  logic signed [AW-1:0] arg_nxt;
  logic signed [NMW-1:0] n_nxt [L];
  logic signed [NMW-1:0] s1122;

  always_comb begin
    s1122 = NMW'(m11) + NMW'(m22);
    if (m33 <= 0) begin
      if (m11 >= m22) begin
        sel_nxt  = rmq_pkg::PIV_C;
        arg_nxt  = ONE + AW'(m11) - AW'(m22) - AW'(m33);
        n_nxt[0] = NMW'(m32) - NMW'(m23);
        n_nxt[1] = NMW'(m31) + NMW'(m13);
        n_nxt[2] = NMW'(m12) + NMW'(m21);
      end else begin
        sel_nxt  = rmq_pkg::PIV_D;
        arg_nxt  = ONE + AW'(m22) - AW'(m11) - AW'(m33);
        n_nxt[0] = NMW'(m13) - NMW'(m31);
        n_nxt[1] = NMW'(m23) + NMW'(m32);
        n_nxt[2] = NMW'(m12) + NMW'(m21);
      end
    end else begin
      if (s1122 >= 0) begin
        sel_nxt  = rmq_pkg::PIV_A;
        arg_nxt  = ONE + AW'(m11) + AW'(m22) + AW'(m33);
        n_nxt[0] = NMW'(m21) - NMW'(m12);
        n_nxt[1] = NMW'(m32) - NMW'(m23);
        n_nxt[2] = NMW'(m13) - NMW'(m31);
      end else begin
        sel_nxt  = rmq_pkg::PIV_B;
        arg_nxt  = ONE + AW'(m33) - AW'(m11) - AW'(m22);
        n_nxt[0] = NMW'(m21) - NMW'(m12);
        n_nxt[1] = NMW'(m31) + NMW'(m13);
        n_nxt[2] = NMW'(m32) + NMW'(m23);
      end
    end
  end

  rmq_pkg::pivot_t       sel_r;
  logic signed [AW-1:0]  arg_r;
  logic signed [NMW-1:0] n_r [L];
  logic                  v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_r <= sel_nxt;
      arg_r <= arg_nxt;
      n_r   <= n_nxt;
    end
  end

  // square root of the clamped argument
  logic [SQW-1:0] sq_x;
  logic [SBW-1:0] sq_sb;
  logic           sq_valid;
  logic [RW-1:0]  sq_root;
  logic [SBW-1:0] sq_sb_out;

  assign sq_x  = arg_r[AW-1] ? '0 : (SQW'(arg_r[AW-2:0]) << (FB-2));
  assign sq_sb = {sel_r, n_r[2], n_r[1], n_r[0]};

  rmq_sqrt #(
    .XW  (SQW),
    .SBW (SBW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v0_r),
    .in_x      (sq_x),
    .in_sb     (sq_sb),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb_out)
  );

  // three divisions by four times the pivot
  logic signed [NMW-1:0] dv_num [L];
  logic                  dv_valid;
  logic [RW-1:0]         dv_p;
  logic signed [DW-1:0]  dv_q [L];
  logic [1:0]            dv_sel;

  for (genvar l = 0; l < L; l++) begin : g_num
    assign dv_num[l] = sq_sb_out[l*NMW +: NMW];
  end

  rmq_div #(
    .DW  (DW),
    .FB  (FB),
    .PW  (RW),
    .SBW (2)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_p      (sq_root),
    .in_num    (dv_num),
    .in_sb     (sq_sb_out[SBW-1:SBW-2]),
    .out_valid (dv_valid),
    .out_p     (dv_p),
    .out_q     (dv_q),
    .out_sb    (dv_sel)
  );

  // place pivot and quotients, zero pivot forces zeros
  logic signed [DW-1:0] pv;
  logic signed [DW-1:0] comp_nxt [4];
  logic                 degen_nxt;

  always_comb begin
    pv        = ((dv_p >> (DW-1)) != '0) ? SMAX : DW'(dv_p);
    degen_nxt = dv_p == '0;
    case (rmq_pkg::pivot_t'(dv_sel))
      rmq_pkg::PIV_A: begin
        comp_nxt[0] = pv;      comp_nxt[1] = dv_q[0];
        comp_nxt[2] = dv_q[1]; comp_nxt[3] = dv_q[2];
      end
      rmq_pkg::PIV_B: begin
        comp_nxt[0] = dv_q[0]; comp_nxt[1] = pv;
        comp_nxt[2] = dv_q[1]; comp_nxt[3] = dv_q[2];
      end
      rmq_pkg::PIV_C: begin
        comp_nxt[0] = dv_q[0]; comp_nxt[1] = dv_q[1];
        comp_nxt[2] = pv;      comp_nxt[3] = dv_q[2];
      end
      default: begin
        comp_nxt[0] = dv_q[0]; comp_nxt[1] = dv_q[1];
        comp_nxt[2] = dv_q[2]; comp_nxt[3] = pv;
      end
    endcase
    if (degen_nxt) begin
      for (int k = 0; k < 4; k++) begin
        comp_nxt[k] = '0;
      end
    end
  end

  // output register
  logic signed [DW-1:0] comp_r [4];
  logic                 degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp_r  <= comp_nxt;
      degen_r <= degen_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = degen_r;
  assign out_tdata  = ODW'({comp_r[3], comp_r[2], comp_r[1], comp_r[0]});

endmodule

`default_nettype wire

/* design/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_checker #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH
) (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tready,
  input wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]    out_tdata,
  input wire logic                                 out_tuser,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready
);

  // a stalled result transfer holds its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // degenerate results carry zero components
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero data");

  // input side is open whenever no result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a taken output frees the input in the same cycle
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_rmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

/* tb/rotation_matrix_to_quaternion_tb.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Streams directed and random matrices through the converter, predicts each
// quaternion with a behavioral Shepperd model and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_tb;

  localparam int DW = rmq_pkg::DATA_WIDTH;
  localparam int FB = rmq_pkg::FRAC_BITS;
  localparam int IN_W = ((9*DW+7)/8)*8;
  localparam int OUT_W = ((4*DW+7)/8)*8;
  localparam int N_RANDOM = 550;

  typedef logic signed [DW-1:0] entry_t;

  typedef struct {
    entry_t comp[4];
    logic   degenerate;
  } quat_t;

  // ---------------------------------------------------------------------------
  // quaternion prediction and in-order checking
  // ---------------------------------------------------------------------------
  class quat_scoreboard;
    quat_t pending[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    static function longint clamp(longint v);
      longint hi;
      hi = (longint'(1) <<< (DW-1)) - 1;
      if (v > hi) return hi;
      if (v < -hi-1) return -hi-1;
      return v;
    endfunction

    static function longint int_sqrt(longint n);
      longint res, bit_v;
      res = 0;
      bit_v = longint'(1) <<< 62;
      while (bit_v > n) bit_v = bit_v >>> 2;
      while (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n = n - (res + bit_v);
          res = (res >>> 1) + bit_v;
        end else begin
          res = res >>> 1;
        end
        bit_v = bit_v >>> 2;
      end
      return res;
    endfunction

    // num / (4 * piv), rounded half away from zero
    static function longint div_round(longint num, longint piv);
      longint mag, den, q;
      mag = (num < 0) ? -num : num;
      den = piv <<< 2;
      q = ((mag <<< FB) + (den >>> 1)) / den;
      if (q > (longint'(1) <<< (DW-1))) q = longint'(1) <<< (DW-1);
      return clamp((num < 0) ? -q : q);
    endfunction

    function void note_matrix(entry_t m[9]);
      longint r11, r12, r13, r21, r22, r23, r31, r32, r33;
      longint arg, n0, n1, n2, piv, pv, q0, q1, q2;
      longint c[4];
      rmq_pkg::pivot_t sel;
      quat_t  e;
      r11 = longint'(m[0]); r12 = longint'(m[1]); r13 = longint'(m[2]);
      r21 = longint'(m[3]); r22 = longint'(m[4]); r23 = longint'(m[5]);
      r31 = longint'(m[6]); r32 = longint'(m[7]); r33 = longint'(m[8]);
      if (r33 <= 0) begin
        if (r11 >= r22) begin
          sel = rmq_pkg::PIV_C; arg = (longint'(1) <<< FB) + r11 - r22 - r33;
          n0 = r32 - r23; n1 = r31 + r13; n2 = r12 + r21;
        end else begin
          sel = rmq_pkg::PIV_D; arg = (longint'(1) <<< FB) + r22 - r11 - r33;
          n0 = r13 - r31; n1 = r23 + r32; n2 = r12 + r21;
        end
      end else begin
        if (r11 + r22 >= 0) begin
          sel = rmq_pkg::PIV_A; arg = (longint'(1) <<< FB) + r11 + r22 + r33;
          n0 = r21 - r12; n1 = r32 - r23; n2 = r13 - r31;
        end else begin
          sel = rmq_pkg::PIV_B; arg = (longint'(1) <<< FB) + r33 - r11 - r22;
          n0 = r21 - r12; n1 = r31 + r13; n2 = r32 + r23;
        end
      end
      if (arg < 0) arg = 0;
      piv = int_sqrt(arg <<< (FB-2));
      if (piv == 0) begin
        foreach (e.comp[k]) e.comp[k] = '0;
        e.degenerate = 1'b1;
      end else begin
        pv = clamp(piv);
        q0 = div_round(n0, piv);
        q1 = div_round(n1, piv);
        q2 = div_round(n2, piv);
        case (sel)
          rmq_pkg::PIV_A: begin c[0] = pv; c[1] = q0; c[2] = q1; c[3] = q2; end
          rmq_pkg::PIV_B: begin c[0] = q0; c[1] = pv; c[2] = q1; c[3] = q2; end
          rmq_pkg::PIV_C: begin c[0] = q0; c[1] = q1; c[2] = pv; c[3] = q2; end
          default: begin
            c[0] = q0; c[1] = q1; c[2] = q2; c[3] = pv;
          end
        endcase
        foreach (e.comp[k]) e.comp[k] = entry_t'(c[k]);
        e.degenerate = 1'b0;
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic degen);
      quat_t  e;
      entry_t got;
      string  names[4];
      names = '{"comp_a", "comp_b", "comp_c", "comp_d"};
      if (pending.size() == 0) begin
        $error("unexpected result transfer %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < 4; k++) begin
        got = data[k*DW +: DW];
        if (got !== e.comp[k]) begin
          $error("%s expected %0d actual %0d", names[k], e.comp[k], got);
          errors++;
        end
      end
      if (degen !== e.degenerate) begin
        $error("degenerate expected %0b actual %0b", e.degenerate, degen);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tvalid;
  logic             out_tready;

  quat_scoreboard sb;
  bit             stim_done;

  rotation_matrix_to_quaternion DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // send one matrix, with a random gap before it
  task automatic send_matrix(entry_t m[9]);
    int gap;
    logic [IN_W-1:0] word;
    gap = int'($urandom_range(0, 3));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    word = '0;
    for (int k = 0; k < 9; k++) word[k*DW +: DW] = m[k];
    in_tdata <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_matrix(m);
    @(negedge clk);
  endtask

  function automatic entry_t rand_entry();
    case ($urandom_range(0, 5))
      0: return entry_t'($urandom);
      1: return entry_t'(32767);
      2: return entry_t'(-32768);
      3: return entry_t'($urandom_range(0, 32) - 16);
      default: return entry_t'($urandom_range(0, 2*(1 << FB)) - (1 << FB));
    endcase
  endfunction

  // rotation-like matrix: small perturbations of a signed permutation
  function automatic void near_rotation(ref entry_t m[9]);
    int perm, sgn;
    perm = int'($urandom_range(0, 2));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m[r*3+c] = entry_t'($urandom_range(0, 4000) - 2000);
      end
      sgn = $urandom_range(0, 1) ? 1 : -1;
      m[r*3 + (r+perm)%3] = entry_t'(sgn * ((1 << FB) - $urandom_range(0, 3000)));
    end
  endfunction

  // stimulus
  initial begin
    entry_t m[9];
    sb = new();
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // identity and the three half-turns, one per pivot case
    m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};   send_matrix(m);
    m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(m);
    // cancelling diagonal terms, root argument of two
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 16384};           send_matrix(m);
    m = '{-16384, 5, 7, 9, 16384, 3, 1, 2, 16384};  send_matrix(m);
    // diagonal at full scale with opposite signs
    m = '{-32768, 100, -100, 50, 32767, 0, 0, 0, 32767}; send_matrix(m);
    // extremes: full-scale entries, one quotient reaching the saturation bound
    m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_matrix(m);
    m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_matrix(m);
    m = '{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 0};
    send_matrix(m);
    m = '{0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};
    send_matrix(m);
    // tie boundaries of the case split
    m = '{100, 1, 2, 3, 100, 4, 5, 6, 0};           send_matrix(m);
    m = '{-100, 1, 2, 3, 100, 4, 5, 6, 1};          send_matrix(m);
    m = '{-101, 1, 2, 3, 100, 4, 5, 6, 1};          send_matrix(m);
    // small off-diagonal numerators, small quotients
    m = '{-16383, 200, -300, 400, -16384, 500, 600, 700, 16384}; send_matrix(m);
    m = '{0, -1, -1, -1, 0, -1, -1, -1, 0};         send_matrix(m);

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        near_rotation(m);
      end else begin
        foreach (m[k]) m[k] = rand_entry();
      end
      send_matrix(m);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side: random stalls, sampled at the rising edge
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = int'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tuser);
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
design/rmq_pkg.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion.sv
design/rmq_checker.sv
tb/rotation_matrix_to_quaternion_tb.sv
